// ===== src/scaled_calendar_clock_defines.svh =====
// Assertion macros used by the calendar clock checker.
`ifndef SCALED_CALENDAR_CLOCK_DEFINES_SVH
`define SCALED_CALENDAR_CLOCK_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SCC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/scc_pkg.sv =====
// Types, constants and codes of the scaled calendar clock.
`default_nettype none

package scc_pkg;

  // Prescaler and configuration port
  localparam int FRAC_BITS_DEF = 8;
  localparam int SPEED_W       = 14;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 14;
  localparam int STEPS_W       = 6;

  localparam logic [SPEED_W-1:0]   SPEED_RESET = 14'd256;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALING_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 1'b1;

  // Item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Calendar limits (one bit wider than their fields) and the step cap
  localparam logic [6:0] SEC_STEP     = 7'd10;
  localparam logic [6:0] SEC_LIMIT    = 7'd60;
  localparam logic [6:0] MIN_LIMIT    = 7'd60;
  localparam logic [5:0] HOUR_LIMIT   = 6'd24;
  localparam logic [5:0] HOUR_DAY     = 6'd6;
  localparam logic [5:0] DAY_LIMIT    = 6'd31;
  localparam logic [5:0] DAY_FIRST    = 6'd1;
  localparam logic [3:0] WDAY_LIMIT   = 4'd7;
  localparam logic [3:0] SEASON_LIMIT = 4'd5;
  localparam logic [3:0] SEASON_FIRST = 4'd1;
  localparam logic [7:0] YEAR_LIMIT   = 8'd100;
  localparam logic [7:0] YEAR_MAX     = 8'd99;
  localparam logic [STEPS_W-1:0] STEPS_SAT = 6'd63;

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [2:0] day_of_week;
    logic [2:0] season;
    logic [6:0] year;
  } clock_t;

  localparam clock_t CLOCK_RESET = '{
    seconds: 6'd0, minutes: 6'd0, hour: 5'd6, day_of_month: 5'd1,
    day_of_week: 3'd0, season: 3'd1, year: 7'd0};

  typedef struct packed {
    logic       opcode;
    logic       advance;
    logic [5:0] load_seconds;
    logic [5:0] load_minutes;
    logic [4:0] load_hour;
    logic [4:0] load_day_of_month;
    logic [2:0] load_day_of_week;
    logic [2:0] load_season;
    logic [6:0] load_year;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         seconds;
    logic [5:0]         minutes;
    logic [4:0]         hour;
    logic [4:0]         day_of_month;
    logic [2:0]         day_of_week;
    logic [2:0]         season;
    logic [2:0]         season_tomorrow;
    logic [6:0]         year;
    logic               month_rolled;
    logic               year_rolled;
    logic [STEPS_W-1:0] steps_taken;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/scc_ifs.sv =====
// Valid/ready channel interfaces for input and result items.
`default_nettype none

interface scc_in_if import scc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scc_out_if import scc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/scc_ctrl.sv =====
// Controller state machine: accept, step loop and result hand-off.
`default_nettype none

module scc_ctrl import scc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STEP = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Sequence one item and hold the result until the output slot frees
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_STEP;
        end
      end
      S_STEP: begin
        if (status.cnt_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.step = 1'b1;
          if (status.cnt_one) state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/scc_dp.sv =====
// Datapath: clock registers, shared carry unit, prescaler and result register.
`default_nettype none

module scc_dp import scc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output out_item_t             out_item
);

  localparam int SUM_W = ((FRAC_BITS > SPEED_W) ? FRAC_BITS : SPEED_W) + 1;
  localparam int CNT_W = SUM_W - FRAC_BITS;
  localparam int CMP_W = (CNT_W > STEPS_W) ? CNT_W : STEPS_W;

  typedef struct packed {
    clock_t tm;
    logic   month;
    logic   year;
  } carry_res_t;

  // One single-pass carry over wide intermediates
  function automatic carry_res_t carry_fn(input logic [6:0] sec_in, input clock_t c);
    logic [6:0] sec;
    logic [6:0] mn;
    logic [5:0] hr;
    logic [5:0] dy;
    logic [3:0] wd;
    logic [3:0] sn;
    logic [7:0] yr;
    carry_res_t r;
    sec     = sec_in;
    mn      = {1'b0, c.minutes};
    hr      = {1'b0, c.hour};
    dy      = {1'b0, c.day_of_month};
    wd      = {1'b0, c.day_of_week};
    sn      = {1'b0, c.season};
    yr      = {1'b0, c.year};
    r.month = 1'b0;
    r.year  = 1'b0;
    if (sec >= SEC_LIMIT) begin
      sec = '0;
      mn  = mn + 7'd1;
    end
    if (mn >= MIN_LIMIT) begin
      mn = '0;
      hr = hr + 6'd1;
      if (hr == HOUR_DAY) begin
        dy = dy + 6'd1;
        wd = wd + 4'd1;
      end
    end
    if (hr >= HOUR_LIMIT) hr = '0;
    if (wd >= WDAY_LIMIT) wd = '0;
    if (dy >= DAY_LIMIT) begin
      dy      = DAY_FIRST;
      sn      = sn + 4'd1;
      r.month = 1'b1;
    end
    if (sn >= SEASON_LIMIT) begin
      sn     = SEASON_FIRST;
      yr     = yr + 8'd1;
      r.year = 1'b1;
    end
    if (yr >= YEAR_LIMIT) yr = YEAR_MAX;
    r.tm.seconds      = sec[5:0];
    r.tm.minutes      = mn[5:0];
    r.tm.hour         = hr[4:0];
    r.tm.day_of_month = dy[4:0];
    r.tm.day_of_week  = wd[2:0];
    r.tm.season       = sn[2:0];
    r.tm.year         = yr[6:0];
    return r;
  endfunction

  clock_t                 time_r, time_nxt;
  logic [FRAC_BITS-1:0]   frac_r, frac_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   month_r, month_nxt;
  logic                   year_r, year_nxt;
  logic [STEPS_W-1:0]     taken_r, taken_nxt;
  logic                   scale_en_r;
  logic [SPEED_W-1:0]     speed_r;
  out_item_t              out_r, out_nxt;

  logic [6:0]             sec_in;
  carry_res_t             cres;
  logic [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]       steps;
  logic [STEPS_W-1:0]     steps_sat;
  logic [5:0]             day_next;
  logic [3:0]             tomorrow;

  // Shared carry unit: a step adds ten seconds first, a normalize does not
  assign sec_in = cmd.step ? ({1'b0, time_r.seconds} + SEC_STEP) : {1'b0, time_r.seconds};
  assign cres   = carry_fn(sec_in, time_r);

  // Prescaler: whole steps above the fraction, fraction kept
  assign sum       = SUM_W'(frac_r) + SUM_W'(speed_r);
  assign steps     = sum[SUM_W-1:FRAC_BITS];
  assign steps_sat = (CMP_W'(steps) > CMP_W'(STEPS_SAT)) ? STEPS_SAT : STEPS_W'(steps);

  // Season of the following day
  always_comb begin
    day_next = {1'b0, time_r.day_of_month} + 6'd1;
    tomorrow = {1'b0, time_r.season};
    if (day_next >= DAY_LIMIT) tomorrow = tomorrow + 4'd1;
    if (tomorrow >= SEASON_LIMIT) tomorrow = SEASON_FIRST;
  end

  // Start an item, or run one step of it
  always_comb begin
    time_nxt  = time_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    taken_nxt = taken_r;
    if (cmd.accept) begin
      cnt_nxt   = '0;
      month_nxt = 1'b0;
      year_nxt  = 1'b0;
      taken_nxt = '0;
      case (in_item.opcode)
        OP_LOAD: begin
          time_nxt.seconds      = in_item.load_seconds;
          time_nxt.minutes      = in_item.load_minutes;
          time_nxt.hour         = in_item.load_hour;
          time_nxt.day_of_month = in_item.load_day_of_month;
          time_nxt.day_of_week  = in_item.load_day_of_week;
          time_nxt.season       = in_item.load_season;
          time_nxt.year         = in_item.load_year;
        end
        OP_TICK: begin
          if (!in_item.advance) begin
            time_nxt  = cres.tm;
            month_nxt = cres.month;
            year_nxt  = cres.year;
          end else if (!scale_en_r) begin
            cnt_nxt   = CNT_W'(1);
            taken_nxt = STEPS_W'(1);
          end else begin
            cnt_nxt   = steps;
            frac_nxt  = sum[FRAC_BITS-1:0];
            taken_nxt = steps_sat;
          end
        end
        default: begin
          time_nxt = time_r;
        end
      endcase
    end else if (cmd.step) begin
      time_nxt  = cres.tm;
      month_nxt = month_r | cres.month;
      year_nxt  = year_r | cres.year;
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  // Assemble the result item
  always_comb begin
    out_nxt.seconds         = time_r.seconds;
    out_nxt.minutes         = time_r.minutes;
    out_nxt.hour            = time_r.hour;
    out_nxt.day_of_month    = time_r.day_of_month;
    out_nxt.day_of_week     = time_r.day_of_week;
    out_nxt.season          = time_r.season;
    out_nxt.season_tomorrow = tomorrow[2:0];
    out_nxt.year            = time_r.year;
    out_nxt.month_rolled    = month_r;
    out_nxt.year_rolled     = year_r;
    out_nxt.steps_taken     = taken_r;
  end

  // Clock state, prescaler and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r     <= CLOCK_RESET;
      frac_r     <= '0;
      cnt_r      <= '0;
      scale_en_r <= 1'b0;
      speed_r    <= SPEED_RESET;
    end else begin
      time_r <= time_nxt;
      frac_r <= frac_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCALING_EN: scale_en_r <= cfg_wdata[0];
          CFG_SPEED:      speed_r    <= cfg_wdata[SPEED_W-1:0];
          default:        speed_r    <= speed_r;
        endcase
      end
    end
  end

  // Flags, step count and result register
  always_ff @(posedge clk) begin
    month_r <= month_nxt;
    year_r  <= year_nxt;
    taken_r <= taken_nxt;
    if (cmd.emit) out_r <= out_nxt;
  end

  assign status.cnt_zero = (cnt_r == '0);
  assign status.cnt_one  = (cnt_r == CNT_W'(1));
  assign out_item        = out_r;

endmodule

`default_nettype wire

// ===== src/scaled_calendar_clock.sv =====
// Top level of the scaled calendar clock: controller, datapath and channel wiring.
//
// Each input item is either a load (sets the clock fields as given, no carry), a
// normalize tick (one carry pass) or an advance tick. An advance tick applies one
// 10-second step, or with scaling enabled adds speed_scale to the fraction
// accumulator (speed_scale is Q(14-FRAC_BITS).FRAC_BITS) and applies the whole
// part as steps, n being the number of steps. Steps run one per cycle through
// a single shared carry unit; loads, normalizes and scaled ticks with no whole
// step run none, and n reaches 64 at FRAC_BITS = 8 and full scale. After the
// last step the result is written to the output register, and the next item
// can be accepted in the following cycle. One item is worked on at a time; the
// next is taken while the previous result still waits in the output register,
// and a further result then waits in the controller until that register frees,
// which stalls the input.
// Configuration is written through cfg_we/cfg_index/cfg_wdata: index 0 is
// scaling_enabled, index 1 is speed_scale.
`default_nettype none

module scaled_calendar_clock import scc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  scc_in_if.sink                in_ch,
  scc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_item;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  scc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

endmodule

`default_nettype wire

// ===== src/scc_checker.sv =====
// Port-level checks of the scaled calendar clock, bound to the top level.
`default_nettype none
`include "scaled_calendar_clock_defines.svh"

module scc_checker import scc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic stalled;
  logic stepped;
  logic fields_in_range;
  logic early_day;

  assign stalled         = out_valid && !out_ready;
  assign stepped         = out_valid && (out_data.steps_taken != 6'd0);
  assign fields_in_range = (out_data.seconds < 6'd60) && (out_data.minutes < 6'd60) &&
                           (out_data.hour < 5'd24) && (out_data.year < 7'd100);
  // a rollover lands on day one; a later step of the same item may pass one more day
  assign early_day       = (out_data.day_of_month == 5'd1) ||
                           (out_data.day_of_month == 5'd2);

  // Result register empties on reset
  `SCC_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result item holds
  `SCC_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_data), "stalled result changed")

  // After at least one step the carry has brought the time fields into range
  `SCC_ASSERT(a_step_range, stepped |-> fields_in_range, "time field out of range after a step")

  // A season rollover leaves one of the first days of the season
  `SCC_ASSERT(a_month_day, out_valid && out_data.month_rolled |-> early_day, "season rolled late")

  // A new year starts in the first season
  `SCC_ASSERT(a_year_season, out_valid && out_data.year_rolled |-> out_data.season == 3'd1, "year rolled without season reset")

endmodule

bind scaled_calendar_clock scc_checker u_scc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
